### rtl/plane_low_discrepancy_points_defines.svh
`ifndef PLANE_LOW_DISCREPANCY_POINTS_DEFINES_SVH
`define PLANE_LOW_DISCREPANCY_POINTS_DEFINES_SVH

// same-cycle implication, reset-qualified
`define PLDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pldp: property violated");

// next-cycle implication, reset-qualified
`define PLDP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pldp: property violated");

`endif

### rtl/pldp_pkg.sv
`default_nettype none

package pldp_pkg;

	localparam int BASE_BITS      = 8;
	localparam int COUNT_BITS     = 21;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 21;
	localparam int DIG_CHUNK      = 4;

	localparam logic MODE_HAMMERSLEY = 1'b0;
	localparam logic MODE_HALTON     = 1'b1;

	localparam logic [BASE_BITS-1:0]  RST_BASE_U      = 8'd2;
	localparam logic [BASE_BITS-1:0]  RST_BASE_V      = 8'd3;
	localparam logic [COUNT_BITS-1:0] RST_POINT_COUNT = 21'd1;
	localparam logic [BASE_BITS-1:0]  MIN_RADIX       = 8'd2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SEQUENCE_MODE = 2'd0,
		CFG_BASE_U        = 2'd1,
		CFG_BASE_V        = 2'd2,
		CFG_POINT_COUNT   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_DIV,
		ST_ACC,
		ST_FLOAD,
		ST_FRAC,
		ST_STORE,
		ST_HAM,
		ST_OUT
	} pldp_state_t;

	typedef struct packed {
		logic item_load;
		logic pass_load;
		logic pass;
		logic div_init;
		logic div_step;
		logic acc;
		logic fri_load;
		logic fham_load;
		logic frac_step;
		logic store_u;
		logic store_v;
		logic sat_v;
		logic out_load;
	} pldp_cmd_t;

	typedef struct packed {
		logic k_zero;
		logic beyond;
		logic halton;
	} pldp_status_t;

endpackage

`default_nettype wire

### rtl/pldp_req_if.sv
`default_nettype none

interface pldp_req_if #(
	parameter int INDEX_BITS = 20
) ();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] point_index;

	modport source (output valid, output point_index, input ready);
	modport sink (input valid, input point_index, output ready);
endinterface

`default_nettype wire

### rtl/pldp_rsp_if.sv
`default_nettype none

interface pldp_rsp_if #(
	parameter int FRAC_BITS = 24
) ();
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] coord_u;
	logic [FRAC_BITS-1:0] coord_v;
	logic                 index_beyond_count;

	modport source (output valid, output coord_u, output coord_v, output index_beyond_count,
		input ready);
	modport sink (input valid, input coord_u, input coord_v, input index_beyond_count,
		output ready);
endinterface

`default_nettype wire

### rtl/pldp_cfg_if.sv
`default_nettype none

interface pldp_cfg_if
	import pldp_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pldp_ctrl.sv
`default_nettype none

module pldp_ctrl
	import pldp_pkg::*;
#(
	parameter int INDEX_BITS = 20,
	parameter int FRAC_BITS  = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	input  pldp_status_t status,
	output pldp_cmd_t    cmd
);

	localparam int DIG_STEPS = (INDEX_BITS + DIG_CHUNK - 1) / DIG_CHUNK;
	localparam int CNT_MAX   = (DIG_STEPS > FRAC_BITS) ? DIG_STEPS : FRAC_BITS;
	localparam int CNT_BITS  = $clog2(CNT_MAX);

	pldp_state_t         state_q;
	pldp_state_t         state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                pass_q;
	logic                out_valid_q;
	logic                cnt_clr;
	logic                cnt_inc;
	logic                pass_set;
	logic                slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid)
					state_d = ST_LOAD;
			end
			ST_LOAD:  state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = status.k_zero ? ST_FLOAD : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_BITS'(DIG_STEPS - 1))
					state_d = ST_ACC;
			end
			ST_ACC:   state_d = ST_CHECK;
			ST_FLOAD: state_d = ST_FRAC;
			ST_FRAC: begin
				if (cnt_q == CNT_BITS'(FRAC_BITS - 1))
					state_d = ST_STORE;
			end
			ST_STORE: begin
				if (pass_q)
					state_d = ST_OUT;
				else if (status.halton)
					state_d = ST_LOAD;
				else
					state_d = ST_HAM;
			end
			ST_HAM: begin
				state_d = status.beyond ? ST_OUT : ST_FRAC;
			end
			ST_OUT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.pass = pass_q;
		cnt_clr  = 1'b0;
		cnt_inc  = 1'b0;
		pass_set = 1'b0;
		case (state_q)
			ST_IDLE:  cmd.item_load = req_valid;
			ST_LOAD:  cmd.pass_load = 1'b1;
			ST_CHECK: begin
				cmd.div_init = !status.k_zero;
				cnt_clr      = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_inc      = 1'b1;
			end
			ST_ACC:   cmd.acc = 1'b1;
			ST_FLOAD: begin
				cmd.fri_load = 1'b1;
				cnt_clr      = 1'b1;
			end
			ST_FRAC: begin
				cmd.frac_step = 1'b1;
				cnt_inc       = 1'b1;
			end
			ST_STORE: begin
				cmd.store_u = !pass_q;
				cmd.store_v = pass_q;
				pass_set    = !pass_q && status.halton;
			end
			ST_HAM: begin
				cmd.sat_v     = status.beyond;
				cmd.fham_load = !status.beyond;
				cnt_clr       = 1'b1;
				pass_set      = 1'b1;
			end
			ST_OUT:   cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr)
				cnt_q <= '0;
			else if (cnt_inc)
				cnt_q <= cnt_q + CNT_BITS'(1);
			if (cmd.item_load)
				pass_q <= 1'b0;
			else if (pass_set)
				pass_q <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/pldp_dpath.sv
`default_nettype none

module pldp_dpath
	import pldp_pkg::*;
#(
	parameter int INDEX_BITS = 20,
	parameter int FRAC_BITS  = 24
) (
	input  logic                  clk,
	input  pldp_cmd_t             cmd,
	output pldp_status_t          status,
	input  logic [INDEX_BITS-1:0] point_index,
	input  logic                  sequence_mode,
	input  logic [BASE_BITS-1:0]  base_u,
	input  logic [BASE_BITS-1:0]  base_v,
	input  logic [COUNT_BITS-1:0] point_count,
	output logic [FRAC_BITS-1:0]  coord_u,
	output logic [FRAC_BITS-1:0]  coord_v,
	output logic                  index_beyond_count
);

	localparam int DIG_STEPS = (INDEX_BITS + DIG_CHUNK - 1) / DIG_CHUNK;
	localparam int PW        = DIG_STEPS * DIG_CHUNK;
	localparam int DW        = (INDEX_BITS + BASE_BITS > COUNT_BITS + 1) ?
		INDEX_BITS + BASE_BITS : COUNT_BITS + 1;
	localparam int CW        = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

	logic [INDEX_BITS-1:0]   kin_q;
	logic [INDEX_BITS-1:0]   k_q;
	logic [BASE_BITS-1:0]    base_q;
	logic [DW-1:0]           mir_q;
	logic [DW-1:0]           scl_q;
	logic [BASE_BITS-1:0]    drem_q;
	logic [PW-1:0]           ddq_q;
	logic [DW-1:0]           frem_q;
	logic [DW-1:0]           fden_q;
	logic [FRAC_BITS-1:0]    fquo_q;
	logic [FRAC_BITS-1:0]    u_q;
	logic [FRAC_BITS-1:0]    v_q;
	logic                    flag_q;
	logic [FRAC_BITS-1:0]    out_u_q;
	logic [FRAC_BITS-1:0]    out_v_q;
	logic                    out_flag_q;

	logic [BASE_BITS-1:0]    radix_sel;
	logic [BASE_BITS-1:0]    radix;
	logic [BASE_BITS-1:0]    drem_nx;
	logic [PW-1:0]           ddq_nx;
	logic [DW+BASE_BITS-1:0] mir_prod;
	logic [DW+BASE_BITS-1:0] scl_prod;
	logic [DW:0]             ftrial;
	logic                    fge;

	assign radix_sel = cmd.pass ? base_v : base_u;
	assign radix     = (radix_sel < MIN_RADIX) ? MIN_RADIX : radix_sel;

	always_comb begin
		logic [BASE_BITS:0]   t;
		logic [BASE_BITS-1:0] r;
		logic [PW-1:0]        dq;
		r  = drem_q;
		dq = ddq_q;
		for (int j = 0; j < DIG_CHUNK; j++) begin
			t  = {r, dq[PW-1]};
			dq = {dq[PW-2:0], 1'b0};
			if (t >= {1'b0, base_q}) begin
				t     = t - {1'b0, base_q};
				dq[0] = 1'b1;
			end
			r = t[BASE_BITS-1:0];
		end
		drem_nx = r;
		ddq_nx  = dq;
	end

	assign mir_prod = (DW + BASE_BITS)'(mir_q) * (DW + BASE_BITS)'(base_q);
	assign scl_prod = (DW + BASE_BITS)'(scl_q) * (DW + BASE_BITS)'(base_q);

	assign ftrial = {frem_q, 1'b0};
	assign fge    = (ftrial >= {1'b0, fden_q});

	assign status.k_zero = (k_q == '0);
	assign status.beyond = (CW'(kin_q) >= CW'(point_count));
	assign status.halton = (sequence_mode == MODE_HALTON);

	always_ff @(posedge clk) begin
		if (cmd.item_load)
			kin_q <= point_index;
		if (cmd.pass_load) begin
			k_q    <= kin_q;
			mir_q  <= '0;
			scl_q  <= DW'(1);
			base_q <= radix;
		end
		if (cmd.div_init) begin
			drem_q <= '0;
			ddq_q  <= PW'(k_q);
		end else if (cmd.div_step) begin
			drem_q <= drem_nx;
			ddq_q  <= ddq_nx;
		end
		if (cmd.acc) begin
			mir_q <= mir_prod[DW-1:0] + DW'(drem_q);
			scl_q <= scl_prod[DW-1:0];
			k_q   <= ddq_q[INDEX_BITS-1:0];
		end
		if (cmd.fri_load) begin
			frem_q <= mir_q;
			fden_q <= scl_q;
			fquo_q <= '0;
		end else if (cmd.fham_load) begin
			frem_q <= DW'({kin_q, 1'b1});
			fden_q <= DW'({point_count, 1'b0});
			fquo_q <= '0;
		end else if (cmd.frac_step) begin
			if (fge)
				frem_q <= DW'(ftrial - {1'b0, fden_q});
			else
				frem_q <= ftrial[DW-1:0];
			fquo_q <= {fquo_q[FRAC_BITS-2:0], fge};
		end
		if (cmd.store_u)
			u_q <= fquo_q;
		if (cmd.store_v)
			v_q <= fquo_q;
		else if (cmd.sat_v)
			v_q <= '1;
		if (cmd.item_load)
			flag_q <= 1'b0;
		else if (cmd.sat_v)
			flag_q <= 1'b1;
		if (cmd.out_load) begin
			out_u_q    <= u_q;
			out_v_q    <= v_q;
			out_flag_q <= flag_q;
		end
	end

	assign coord_u            = out_u_q;
	assign coord_v            = out_v_q;
	assign index_beyond_count = out_flag_q;

endmodule

`default_nettype wire

### rtl/plane_low_discrepancy_points.sv
// channel | dir | fields                                        | handshake
// req     | in  | point_index                                   | valid/ready
// rsp     | out | coord_u, coord_v, index_beyond_count          | valid/ready
// cfg     | in  | index, data                                   | valid/ready, ready tied high
//
// One item at a time; req stalls until the previous item leaves the core. For u, the
// index is split into base_u digits, one digit division (4 quotient bits a cycle) each,
// and the reversed digits pass through the 1-bit-a-cycle fraction divider; v repeats this
// in Halton mode, is (2*index+1)/(2*count) in Hammersley mode, or saturates when beyond count.
// Async reset clears the control state and config registers, not the datapath registers.
// A finished word waits in the rsp register while the next word is taken on req.
`default_nettype none

module plane_low_discrepancy_points
	import pldp_pkg::*;
#(
	parameter int INDEX_BITS = 20,
	parameter int FRAC_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	pldp_req_if.sink   req,
	pldp_rsp_if.source rsp,
	pldp_cfg_if.sink   cfg
);

	logic                  mode_q;
	logic [BASE_BITS-1:0]  base_u_q;
	logic [BASE_BITS-1:0]  base_v_q;
	logic [COUNT_BITS-1:0] count_q;
	pldp_cmd_t             cmd;
	pldp_status_t          status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_HAMMERSLEY;
			base_u_q <= RST_BASE_U;
			base_v_q <= RST_BASE_V;
			count_q  <= RST_POINT_COUNT;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_SEQUENCE_MODE: mode_q   <= cfg.data[0];
				CFG_BASE_U:        base_u_q <= cfg.data[BASE_BITS-1:0];
				CFG_BASE_V:        base_v_q <= cfg.data[BASE_BITS-1:0];
				CFG_POINT_COUNT:   count_q  <= cfg.data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	pldp_ctrl #(
		.INDEX_BITS(INDEX_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pldp_dpath #(
		.INDEX_BITS(INDEX_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk               (clk),
		.cmd               (cmd),
		.status            (status),
		.point_index       (req.point_index),
		.sequence_mode     (mode_q),
		.base_u            (base_u_q),
		.base_v            (base_v_q),
		.point_count       (count_q),
		.coord_u           (rsp.coord_u),
		.coord_v           (rsp.coord_v),
		.index_beyond_count(rsp.index_beyond_count)
	);

endmodule

`default_nettype wire

### rtl/pldp_checker.sv
`default_nettype none
`include "plane_low_discrepancy_points_defines.svh"

module pldp_checker #(
	parameter int FRAC_BITS = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [FRAC_BITS-1:0] rsp_coord_u,
	input logic [FRAC_BITS-1:0] rsp_coord_v,
	input logic                 rsp_flag
);

	`PLDP_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coord_u) && $stable(rsp_coord_v) && $stable(rsp_flag))
	`PLDP_ASSERT_IMP(a_flag_sat, clk, arst_n, rsp_valid && rsp_flag, &rsp_coord_v)
	`PLDP_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)
	`PLDP_ASSERT_IMP(a_rsp_after_busy, clk, arst_n, $rose(rsp_valid), !$past(req_ready))

endmodule

bind plane_low_discrepancy_points pldp_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_pldp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_coord_u(rsp.coord_u),
	.rsp_coord_v(rsp.coord_v),
	.rsp_flag   (rsp.index_beyond_count)
);

`default_nettype wire
